>>> hdl/ftra_pkg.sv
// Shared types and constants for the fan tach speed averager.
// No dependencies; imported by every module of the block.
`default_nettype none

package ftra_pkg;

    // Field and storage widths
    localparam int DATA_W    = 32;
    localparam int SAMPLES   = 8;
    localparam int POS_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int SUM_W     = DATA_W + POS_W;
    localparam int RPM_W     = 16;
    localparam int CFG_IDX_W = 8;

    // Speed numerator: microseconds per minute times ring depth
    localparam longint unsigned US_PER_MINUTE = 64'd60000000;
    localparam longint unsigned DIVIDEND      = US_PER_MINUTE * SAMPLES;
    localparam int              NUM_W         = $clog2(DIVIDEND + 1);
    localparam int              CNT_W         = $clog2(NUM_W);

    // Limit register reset values
    localparam logic [DATA_W-1:0] SLOW_RESET = 32'd1000000;
    localparam logic [DATA_W-1:0] FAST_RESET = 32'd3000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_LIMIT = CFG_IDX_W'(1);

    // Item opcodes
    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result event codes
    typedef enum logic [2:0] {
        EV_FIRST   = 3'd0,
        EV_STORED  = 3'd1,
        EV_CLAMPED = 3'd2,
        EV_OUTLIER = 3'd3,
        EV_STOPPED = 3'd4,
        EV_QUERY   = 3'd5
    } t_event;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // take the input item
        logic calc_diff;   // interval since last edge
        logic calc_bound;  // clamp bounds, limit compares, ring delta
        logic judge;       // classify and update measurement state
        logic div_start;   // launch the speed division
        logic out_load;    // move the result into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;    // query needs a quotient
        logic div_done;    // quotient ready
        logic out_free;    // output register can take a result
    } t_stat;

endpackage

`default_nettype wire

>>> hdl/ftra_div.sv
// Restoring divider, one quotient bit per cycle, fixed speed numerator.
// Depends on ftra_pkg.
`default_nettype none

module ftra_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ftra_pkg::SUM_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [ftra_pkg::NUM_W-1:0]     o_quot
);
    import ftra_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;   // dividend bits shift out, quotient bits shift in
    logic [SUM_W-1:0] r_dvs;

    logic [SUM_W:0]   w_trial;
    logic [SUM_W:0]   w_diff;
    logic             w_ge;

    // One trial subtraction
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= NUM_W'(DIVIDEND);
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SUM_W-1:0] : w_trial[SUM_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    // A new division never starts on top of a running one
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    // Done follows the last step
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a finished run");

endmodule

`default_nettype wire

>>> hdl/ftra_dp.sv
// Datapath: limit registers, edge/interval state, sample ring with running
// sum, speed divider and output register. Depends on ftra_pkg, ftra_div.
`default_nettype none

module ftra_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ftra_pkg::t_cmd                i_cmd,
    output ftra_pkg::t_stat                    o_stat,
    // item payload
    input  wire logic                          i_op,
    input  wire logic [ftra_pkg::DATA_W-1:0]   i_time_us,
    // configuration
    input  wire logic                          i_cfg_valid,
    input  wire logic [ftra_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ftra_pkg::DATA_W-1:0]   i_cfg_data,
    // result
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [ftra_pkg::RPM_W-1:0]         o_rpm,
    output logic                               o_running,
    output logic [2:0]                         o_event_res
);
    import ftra_pkg::*;

    // Limits
    logic [DATA_W-1:0] r_slow;
    logic [DATA_W-1:0] r_fast;

    // Captured item and intermediate values
    logic              r_op;
    logic [DATA_W-1:0] r_time;
    logic [DATA_W-1:0] r_m;
    logic [DATA_W-1:0] r_lo;
    logic [DATA_W:0]   r_hi;
    logic [DATA_W:0]   r_delta;
    logic              r_stop;
    logic              r_fast_hit;

    // Measurement state
    logic [DATA_W-1:0] r_last_edge;
    logic              r_have_edge;
    logic [DATA_W-1:0] r_last_int;
    logic              r_valid;
    logic [DATA_W-1:0] r_ring [SAMPLES];
    logic [POS_W-1:0]  r_pos;
    logic [SUM_W-1:0]  r_sum;
    logic              r_use_q;
    t_event            r_event;

    // Output register
    logic              r_out_valid;
    logic [RPM_W-1:0]  r_out_rpm;
    logic              r_out_running;
    t_event            r_out_event;

    logic              w_div_done;
    logic [NUM_W-1:0]  w_quot;
    logic [RPM_W-1:0]  w_rpm_sat;
    logic [DATA_W-1:0] w_quarter;
    logic [DATA_W:0]   w_lo_diff;
    logic              w_need_div;
    logic              w_below_lo;
    logic              w_above_hi;

    // Limit register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow <= SLOW_RESET;
            r_fast <= FAST_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SLOW_LIMIT: r_slow <= i_cfg_data;
                CFG_FAST_LIMIT: r_fast <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Bound arithmetic
    assign w_quarter = r_m >> 2;
    assign w_lo_diff = {1'b0, r_last_int} - {1'b0, w_quarter};

    // Classification inputs
    assign w_below_lo = (r_m < r_lo);
    assign w_above_hi = ({1'b0, r_m} > r_hi);
    assign w_need_div = (r_op == OP_QUERY) && r_valid && !r_stop && (r_sum != '0);

    // Item capture and per-step scratch values
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_time <= i_time_us;
        end
        if (i_cmd.calc_diff) begin
            r_m <= r_time - r_last_edge;
        end
        if (i_cmd.calc_bound) begin
            r_lo       <= w_lo_diff[DATA_W] ? '0 : w_lo_diff[DATA_W-1:0];
            r_hi       <= {1'b0, r_last_int} + {1'b0, w_quarter};
            r_delta    <= {1'b0, r_m} - {1'b0, r_ring[r_pos]};
            r_stop     <= (r_m > r_slow);
            r_fast_hit <= (r_m < r_fast);
        end
    end

    // Judgement: update measurement state and pick the event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge <= '0;
            r_have_edge <= 1'b0;
            r_last_int  <= '0;
            r_valid     <= 1'b0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_use_q     <= 1'b0;
            r_event     <= EV_FIRST;
            for (int i = 0; i < SAMPLES; i++) begin
                r_ring[i] <= '0;
            end
        end else if (i_cmd.judge) begin
            r_use_q <= w_need_div;
            if (r_op == OP_QUERY) begin
                if (r_valid && r_stop) begin
                    r_have_edge <= 1'b0;
                    r_last_int  <= '0;
                    r_valid     <= 1'b0;
                    r_event     <= EV_STOPPED;
                end else begin
                    r_event <= EV_QUERY;
                end
            end else if (!r_have_edge) begin
                r_last_edge <= r_time;
                r_have_edge <= 1'b1;
                r_event     <= EV_FIRST;
            end else if (r_stop) begin
                r_have_edge <= 1'b0;
                r_last_int  <= '0;
                r_valid     <= 1'b0;
                r_event     <= EV_STOPPED;
            end else if (r_fast_hit) begin
                r_event <= EV_OUTLIER;
            end else begin
                r_last_edge <= r_time;
                if (r_last_int != '0 && w_below_lo) begin
                    r_last_int <= r_lo;
                    r_event    <= EV_CLAMPED;
                end else if (r_last_int != '0 && w_above_hi) begin
                    r_last_int <= r_hi[DATA_W-1:0];
                    r_event    <= EV_CLAMPED;
                end else begin
                    // store into the ring
                    r_ring[r_pos] <= r_m;
                    r_sum         <= r_sum + {{(SUM_W-DATA_W-1){r_delta[DATA_W]}}, r_delta};
                    r_pos         <= (r_pos == POS_W'(SAMPLES - 1)) ? '0 : r_pos + 1'b1;
                    r_valid       <= 1'b1;
                    r_last_int    <= r_m;
                    r_event       <= EV_STORED;
                end
            end
        end
    end

    // Speed quotient
    ftra_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_divisor (r_sum),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    assign w_rpm_sat = (|w_quot[NUM_W-1:RPM_W]) ? '1 : w_quot[RPM_W-1:0];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rpm     <= r_use_q ? w_rpm_sat : '0;
            r_out_running <= r_valid;
            r_out_event   <= r_event;
        end
    end

    assign o_stat.need_div = w_need_div;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = !r_out_valid || i_ready;

    assign o_valid     = r_out_valid;
    assign o_rpm       = r_out_rpm;
    assign o_running   = r_out_running;
    assign o_event_res = r_out_event;

    // A valid measurement always has a reference edge
    a_valid_has_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_have_edge)
        else $error("valid measurement without reference edge");

    // A held interval implies a reference edge
    a_interval_has_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last_int != '0) |-> r_have_edge)
        else $error("last interval held without reference edge");

    // A stop result never reports running
    a_stop_not_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_event == EV_STOPPED) |=> !r_out_running)
        else $error("stopped result reports running");

endmodule

`default_nettype wire

>>> hdl/ftra_ctrl.sv
// Controller: sequences one item through the datapath steps.
// Depends on ftra_pkg.
`default_nettype none

module ftra_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire ftra_pkg::t_stat i_stat,
    output ftra_pkg::t_cmd      o_cmd
);
    import ftra_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_BOUND,
        S_JUDGE,
        S_DIV,
        S_PUT
    } t_state;

    t_state r_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:  if (i_valid) r_state <= S_DIFF;
                S_DIFF:  r_state <= S_BOUND;
                S_BOUND: r_state <= S_JUDGE;
                S_JUDGE: r_state <= i_stat.need_div ? S_DIV : S_PUT;
                S_DIV:   if (i_stat.div_done) r_state <= S_PUT;
                S_PUT:   if (i_stat.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Command decode
    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = (r_state == S_IDLE) && i_valid;
        o_cmd.calc_diff  = (r_state == S_DIFF);
        o_cmd.calc_bound = (r_state == S_BOUND);
        o_cmd.judge      = (r_state == S_JUDGE);
        o_cmd.div_start  = (r_state == S_JUDGE) && i_stat.need_div;
        o_cmd.out_load   = (r_state == S_PUT) && i_stat.out_free;
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

>>> hdl/fan_tach_rpm_averager.sv
// Top level of the fan tach speed averager: controller plus datapath.
// Depends on ftra_pkg, ftra_ctrl, ftra_dp.
//
//   channel   direction  handshake                  payload
//   item      in         i_valid / o_ready          i_op, i_time_us
//   result    out        o_valid / i_ready          o_rpm, o_running, o_event_res
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A pulse or an unanswered query passes the DIFF, BOUND, JUDGE and PUT steps; a query
// that needs a quotient also waits in DIV for the one-bit-per-cycle restoring
// divider. The block returns to idle as the result is loaded into the output
// register and can then take the next item.
// Reset is synchronous; the sample ring clears at once, no clearing pass.
// A stalled result holds the block in its output step until transferred.
`default_nettype none

module fan_tach_rpm_averager (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // item channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_op,
    input  wire logic [ftra_pkg::DATA_W-1:0]    i_time_us,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [ftra_pkg::RPM_W-1:0]          o_rpm,
    output logic                                o_running,
    output logic [2:0]                          o_event_res,
    // configuration channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ftra_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ftra_pkg::DATA_W-1:0]    i_cfg_data
);
    import ftra_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    ftra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    ftra_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_op        (i_op),
        .i_time_us   (i_time_us),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rpm       (o_rpm),
        .o_running   (o_running),
        .o_event_res (o_event_res)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for fan_tach_rpm_averager: tach pulses and speed queries
// go in under random stalls; every result is predicted and checked on transfer.
// Depends on ftra_pkg and the fan_tach_rpm_averager RTL.
module tb_top;
    import ftra_pkg::*;

    typedef struct {
        logic              op;
        logic [DATA_W-1:0] time_us;
        logic              drain;    // wait for all results before sending
    } t_tach_item;

    typedef struct {
        logic [RPM_W-1:0] rpm;
        logic             running;
        t_event           ev;
    } t_speed_res;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;
    localparam logic [DATA_W-1:0]    T0         = 32'hFFFF_F000;
    localparam longint unsigned      RPM_NUM    = 64'd60000000 * SAMPLES;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_op;
    logic [DATA_W-1:0]    i_time_us;
    logic                 o_valid;
    logic                 i_ready;
    logic [RPM_W-1:0]     o_rpm;
    logic                 o_running;
    logic [2:0]           o_event_res;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    // Stimulus and scoreboard
    t_tach_item  item_q [$];
    t_speed_res  speed_exp_q [$];
    int unsigned gap_pct;
    logic [DATA_W-1:0] stim_now;
    int unsigned err_cnt, items_done, query_cnt, cfg_cnt, sat_cnt;
    int unsigned ev_cnt [8];

    // Speed averager prediction state
    logic [DATA_W-1:0] lim_slow, lim_fast;
    logic [DATA_W-1:0] fan_edge_t;
    logic              fan_edge_held;
    logic [DATA_W-1:0] fan_last_iv;
    logic              fan_meas_ok;
    logic [DATA_W-1:0] fan_iv_ring [SAMPLES];
    int unsigned       fan_ring_idx;
    longint unsigned   fan_iv_sum;

    fan_tach_rpm_averager i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_time_us   (i_time_us),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rpm       (o_rpm),
        .o_running   (o_running),
        .o_event_res (o_event_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Fan stopped: drop the edge and the measurement, ring is kept
    function automatic void fan_stop();
        fan_edge_held = 1'b0;
        fan_last_iv   = '0;
        fan_meas_ok   = 1'b0;
    endfunction

    // Expected result of one pulse or query; updates the fan state
    function automatic t_speed_res predict_speed(input logic op,
                                                 input logic [DATA_W-1:0] t);
        t_speed_res        res;
        logic [DATA_W-1:0] gap;
        longint unsigned   quo, d, lo, hi, last;
        res.rpm = '0;
        res.ev  = EV_QUERY;
        gap     = t - fan_edge_t;
        if (op == OP_QUERY) begin
            if (fan_meas_ok && gap > lim_slow) begin
                fan_stop();
                res.ev = EV_STOPPED;
            end else if (fan_meas_ok && fan_iv_sum != 0) begin
                quo = RPM_NUM / fan_iv_sum;
                if (quo > 65535) begin
                    quo = 65535;
                    sat_cnt++;
                end
                res.rpm = quo[RPM_W-1:0];
            end
        end else if (!fan_edge_held) begin
            fan_edge_t    = t;
            fan_edge_held = 1'b1;
            res.ev        = EV_FIRST;
        end else if (gap > lim_slow) begin
            fan_stop();
            res.ev = EV_STOPPED;
        end else if (gap < lim_fast) begin
            res.ev = EV_OUTLIER;
        end else begin
            fan_edge_t = t;
            // Window of the last interval +/- a quarter of the new gap, low side floored at zero
            d    = gap >> 2;
            last = fan_last_iv;
            lo   = (last > d) ? last - d : 0;
            hi   = last + d;
            if (last != 0 && (gap < lo || gap > hi)) begin
                fan_last_iv = (gap < lo) ? lo[DATA_W-1:0] : hi[DATA_W-1:0];
                res.ev      = EV_CLAMPED;
            end else begin
                fan_iv_sum                = fan_iv_sum + gap - fan_iv_ring[fan_ring_idx];
                fan_iv_ring[fan_ring_idx] = gap;
                fan_ring_idx              = (fan_ring_idx + 1) % SAMPLES;
                fan_meas_ok               = 1'b1;
                fan_last_iv               = gap;
                res.ev                    = EV_STORED;
            end
        end
        res.running = fan_meas_ok;
        return res;
    endfunction

    function automatic void queue_item(input logic op, input logic [DATA_W-1:0] t,
                                       input logic hold);
        item_q.push_back('{op, t, hold});
    endfunction

    // Fan running near a drifting period: mostly clean pulses and queries,
    // with swings, outliers, stops and random noise mixed in
    task automatic gen_fan(input int n, input int unsigned per_lo, input int unsigned per_hi,
                           input int unsigned noise_pct);
        logic [DATA_W-1:0] edge_t;
        int unsigned       period, jit, r;
        logic              hold;
        edge_t = stim_now;
        period = $urandom_range(per_hi, per_lo);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(39, 0) == 0)
                period = $urandom_range(per_hi, per_lo);
            jit  = period / 10;
            r    = $urandom_range(99, 0);
            hold = $urandom_range(99, 0) == 0;
            if (r < noise_pct) begin
                queue_item(1'($urandom), $urandom, hold);
            end else if (r < 52) begin
                edge_t = edge_t + period - jit + $urandom_range(2 * jit, 0);
                queue_item(OP_PULSE, edge_t, hold);
            end else if (r < 58) begin
                edge_t = edge_t + 32'(64'(period) * $urandom_range(170, 30) / 100);
                queue_item(OP_PULSE, edge_t, hold);
            end else if (r < 62 && lim_fast != 0) begin
                queue_item(OP_PULSE, edge_t + $urandom_range(lim_fast - 1, 0), hold);
            end else if (r < 65) begin
                edge_t = edge_t + lim_slow + 1 + $urandom_range(period, 0);
                queue_item(OP_PULSE, edge_t, hold);
            end else if (r < 68) begin
                queue_item(OP_QUERY, edge_t + lim_slow + 1 + $urandom_range(999, 0), hold);
            end else begin
                queue_item(OP_QUERY, edge_t + $urandom_range(period, 0), hold);
            end
        end
        stim_now = edge_t;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (item_q.size() != 0 || i_valid || speed_exp_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Item driver: next pending item, random idle cycles, optional drain
    always @(posedge i_clk) begin : item_driver
        t_tach_item nxt;
        logic       go;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            go = item_q.size() != 0 && $urandom_range(99, 0) >= gap_pct;
            if (go && item_q[0].drain)
                go = !i_valid && speed_exp_q.size() == 0;
            if (go) begin
                nxt = item_q.pop_front();
                i_op      <= nxt.op;
                i_time_us <= nxt.time_us;
            end
            i_valid <= go;
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= $urandom_range(99, 0) >= gap_pct;
    end

    // Monitor: config and item transfers feed the predictor, results are checked
    always @(posedge i_clk) begin : monitor
        t_speed_res want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLOW_LIMIT: lim_slow = i_cfg_data;
                    CFG_FAST_LIMIT: lim_fast = i_cfg_data;
                    default: ;
                endcase
                cfg_cnt++;
            end
            if (i_valid && o_ready) begin
                want = predict_speed(i_op, i_time_us);
                speed_exp_q.push_back(want);
                ev_cnt[want.ev]++;
                items_done++;
                if (i_op == OP_QUERY)
                    query_cnt++;
            end
            if (o_valid && i_ready) begin
                if (speed_exp_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: result transfer with no item outstanding", $time);
                end else begin
                    want = speed_exp_q.pop_front();
                    if (o_rpm !== want.rpm || o_running !== want.running ||
                        o_event_res !== want.ev) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"%0t: mismatch, expected rpm %0d running %0b event %0d,",
                                      " got rpm %0d running %0b event %0d"}, $time,
                                     want.rpm, want.running, want.ev,
                                     o_rpm, o_running, o_event_res);
                    end
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_op        = OP_PULSE;
        i_time_us   = '0;
        i_ready     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        gap_pct     = 32;
        lim_slow      = SLOW_RESET;
        lim_fast      = FAST_RESET;
        fan_edge_t    = '0;
        fan_edge_held = 1'b0;
        fan_last_iv   = '0;
        fan_meas_ok   = 1'b0;
        fan_ring_idx  = 0;
        fan_iv_sum    = 0;
        foreach (fan_iv_ring[k]) fan_iv_ring[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset limits: no measurement, first edge, outlier just under
        // the fast limit, store across the timestamp wrap, clamps both ways,
        // exact window bounds, query at and past the slow limit, stop on pulse
        queue_item(OP_QUERY, T0, 1'b0);
        queue_item(OP_PULSE, T0, 1'b0);
        queue_item(OP_PULSE, T0 + 32'd2999, 1'b0);
        queue_item(OP_PULSE, T0 + 32'd20000, 1'b0);
        queue_item(OP_QUERY, T0 + 32'd25000, 1'b0);
        queue_item(OP_PULSE, T0 + 32'd40000, 1'b0);
        queue_item(OP_PULSE, T0 + 32'd80000, 1'b0);
        queue_item(OP_PULSE, T0 + 32'd90000, 1'b0);
        queue_item(OP_PULSE, T0 + 32'd117500, 1'b0);
        queue_item(OP_PULSE, T0 + 32'd154166, 1'b0);
        queue_item(OP_PULSE, T0 + 32'd183499, 1'b0);
        queue_item(OP_QUERY, T0 + 32'd1183499, 1'b0);
        queue_item(OP_QUERY, T0 + 32'd1183500, 1'b0);
        queue_item(OP_PULSE, 32'hFFFF_FFFF, 1'b0);
        queue_item(OP_PULSE, 32'd1000000, 1'b0);
        queue_item(OP_PULSE, 32'd0, 1'b0);
        queue_item(OP_PULSE, 32'd3000, 1'b0);
        stim_now = 32'd3000;
        gen_fan(180, 3000, 600000, 10);
        wait_drained();

        // Mid limits, no idling on either side
        write_reg(CFG_SLOW_LIMIT, 32'd200000);
        write_reg(CFG_FAST_LIMIT, 32'd1000);
        gap_pct = 0;
        gen_fan(180, 1000, 150000, 8);
        wait_drained();

        // Widest limits and short periods: saturated answers
        write_reg(CFG_SLOW_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_FAST_LIMIT, 32'd1);
        gap_pct = 32;
        gen_fan(200, 1, 2000, 10);
        wait_drained();

        // Zero fast limit: stop, then eight zero intervals empty the sum
        write_reg(CFG_SLOW_LIMIT, 32'd50000);
        write_reg(CFG_FAST_LIMIT, 32'd0);
        queue_item(OP_PULSE, stim_now, 1'b0);
        queue_item(OP_PULSE, stim_now, 1'b0);
        queue_item(OP_PULSE, stim_now + 32'd50001, 1'b0);
        stim_now = stim_now + 32'd60000;
        repeat (9) queue_item(OP_PULSE, stim_now, 1'b0);
        queue_item(OP_QUERY, stim_now, 1'b0);
        gen_fan(120, 1, 40000, 10);
        wait_drained();

        // Slow limit zero: any nonzero interval stops the fan
        write_reg(CFG_SLOW_LIMIT, 32'd0);
        gen_fan(70, 0, 1000, 10);
        wait_drained();

        // Everything an outlier or a stop; unused register index
        write_reg(CFG_SLOW_LIMIT, 32'd1);
        write_reg(CFG_FAST_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        gen_fan(60, 0, 3, 10);
        wait_drained();

        // Back to the reset limits for a long random run
        write_reg(CFG_SLOW_LIMIT, SLOW_RESET);
        write_reg(CFG_FAST_LIMIT, FAST_RESET);
        gen_fan(300, 3000, 200000, 10);
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (speed_exp_q.size() != 0)
            err_cnt += speed_exp_q.size();
        $display("Run covered %0d items (%0d queries), %0d register writes, %0d mismatches.",
                 items_done, query_cnt, cfg_cnt, err_cnt);
        $display({"Kinds seen: first %0d, stored %0d, clamped %0d, outlier %0d,",
                  " stopped %0d, answered %0d (%0d saturated)."},
                 ev_cnt[EV_FIRST], ev_cnt[EV_STORED], ev_cnt[EV_CLAMPED],
                 ev_cnt[EV_OUTLIER], ev_cnt[EV_STOPPED], ev_cnt[EV_QUERY], sat_cnt);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
